[design/adsr_pkg.sv]
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants of the ADSR envelope generator
// Level format, phase and action codes, register indexes, item structs.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Fixed point: 1.0 = 2^FRAC_BITS
  localparam int unsigned FRAC_BITS = 23;

  localparam int unsigned REG_W   = 24;   // configuration register width
  localparam int unsigned OUT_W   = 24;   // level field width
  localparam int unsigned IDX_W   = 8;    // configuration index width
  localparam int unsigned PH_W    = 3;
  localparam int unsigned ACT_W   = 2;

  // Internal level must hold full scale and any sustain level up to 2^REG_W-1
  localparam int unsigned LVL_W = (FRAC_BITS + 1 > REG_W) ? FRAC_BITS + 1 : REG_W;

  localparam logic [LVL_W:0] FULL_SCALE =
    {{(LVL_W - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ATK_RATE      = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DCY_RATE      = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_SUSTAIN_LEVEL = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_REL_RATE      = IDX_W'(3);

  // Reset values
  localparam logic [REG_W-1:0] RST_ATK_RATE      = REG_W'(1);
  localparam logic [REG_W-1:0] RST_DCY_RATE      = REG_W'(1);
  localparam logic [REG_W-1:0] RST_SUSTAIN_LEVEL = REG_W'(4194304);
  localparam logic [REG_W-1:0] RST_REL_RATE      = REG_W'(1);

  typedef enum logic [PH_W-1:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_ENDED   = 3'd4
  } phase_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_NOTE_ON  = 2'd1,
    ACT_NOTE_OFF = 2'd2
  } action_e;

  typedef struct packed {
    logic [REG_W-1:0] atk_rate;
    logic [REG_W-1:0] dcy_rate;
    logic [REG_W-1:0] sustain_level;
    logic [REG_W-1:0] rel_rate;
  } cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             zero_level_on_start;
    logic             hold_sustain;
  } item_t;

endpackage

[design/adsr_if.sv]
// ----------------------------------------------------------------------------
// adsr_if: valid/ready channels of the ADSR envelope generator
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface adsr_item_if import adsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic             zero_level_on_start;
  logic             hold_sustain;

  modport source (output valid, action, zero_level_on_start, hold_sustain, input ready);
  modport sink   (input valid, action, zero_level_on_start, hold_sustain, output ready);
endinterface

interface adsr_result_if import adsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] level;
  logic [PH_W-1:0]  phase;

  modport source (output valid, level, phase, input ready);
  modport sink   (input valid, level, phase, output ready);
endinterface

interface adsr_cfg_if import adsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [REG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/adsr_cfg.sv]
// ----------------------------------------------------------------------------
// adsr_cfg: configuration register file
// Four step and level registers, written one beat at a time by index.
// ----------------------------------------------------------------------------
module adsr_cfg import adsr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  adsr_cfg_if.sink        cfg_i,
  output cfg_t            cfg_o
);

  cfg_t regs_q, regs_d;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  always_comb begin
    regs_d = regs_q;
    if (wr_en) begin
      case (cfg_i.index)
        REG_ATK_RATE:      regs_d.atk_rate      = cfg_i.data;
        REG_DCY_RATE:      regs_d.dcy_rate      = cfg_i.data;
        REG_SUSTAIN_LEVEL: regs_d.sustain_level = cfg_i.data;
        REG_REL_RATE:      regs_d.rel_rate      = cfg_i.data;
        default:           regs_d = regs_q;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.atk_rate      <= RST_ATK_RATE;
      regs_q.dcy_rate      <= RST_DCY_RATE;
      regs_q.sustain_level <= RST_SUSTAIN_LEVEL;
      regs_q.rel_rate      <= RST_REL_RATE;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o = regs_q;

endmodule

[design/adsr_core.sv]
// ----------------------------------------------------------------------------
// adsr_core: envelope phase state machine and level datapath
// Holds phase and level; applies one item per step with saturating clamps.
// ----------------------------------------------------------------------------
module adsr_core import adsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  item_t            item_i,
  input  cfg_t             cfg_i,
  output logic [OUT_W-1:0] level_o,
  output phase_e           phase_o
);

  phase_e           phase_q, phase_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;

  logic [LVL_W:0]   att_sum;
  logic [LVL_W:0]   dec_thr;
  logic             att_done, dec_done, rel_done;

  // Clamp conditions, evaluated one bit wider so nothing wraps
  assign att_sum  = {1'b0, lvl_q} + (LVL_W+1)'(cfg_i.atk_rate);
  assign dec_thr  = (LVL_W+1)'(cfg_i.sustain_level) + (LVL_W+1)'(cfg_i.dcy_rate);
  assign att_done = att_sum >= FULL_SCALE;
  assign dec_done = {1'b0, lvl_q} <= dec_thr;
  assign rel_done = lvl_q <= LVL_W'(cfg_i.rel_rate);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    case (item_i.action)
      ACT_NOTE_ON:  phase_d = PH_ATTACK;
      ACT_NOTE_OFF: phase_d = PH_RELEASE;
      ACT_TICK: begin
        case (phase_q)
          PH_ATTACK:  if (att_done) phase_d = PH_DECAY;
          PH_DECAY:   if (dec_done) phase_d = item_i.hold_sustain ? PH_SUSTAIN : PH_RELEASE;
          PH_RELEASE: if (rel_done) phase_d = PH_ENDED;
          default:    phase_d = phase_q;
        endcase
      end
      default: phase_d = phase_q;
    endcase
  end

  // Level datapath
  always_comb begin
    lvl_d = lvl_q;
    case (item_i.action)
      ACT_NOTE_ON: begin
        if (item_i.zero_level_on_start) lvl_d = '0;
      end
      ACT_TICK: begin
        case (phase_q)
          PH_ATTACK:  lvl_d = att_done ? FULL_SCALE[LVL_W-1:0] : att_sum[LVL_W-1:0];
          PH_DECAY:   lvl_d = dec_done ? LVL_W'(cfg_i.sustain_level)
                                       : lvl_q - LVL_W'(cfg_i.dcy_rate);
          PH_RELEASE: lvl_d = rel_done ? '0 : lvl_q - LVL_W'(cfg_i.rel_rate);
          default:    lvl_d = lvl_q;
        endcase
      end
      default: lvl_d = lvl_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ENDED;
      lvl_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      lvl_q   <= lvl_d;
    end
  end

  // Result of this step
  assign level_o = lvl_d[OUT_W-1:0];
  assign phase_o = phase_d;

  // Release only ends by clamping at zero, and note-on leaves zero alone
  a_ended_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ENDED |-> lvl_q == '0)
    else $error("ended phase with nonzero level");

  a_sustain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == ACT_TICK && phase_q == PH_SUSTAIN
    |=> lvl_q == $past(lvl_q) && phase_q == PH_SUSTAIN)
    else $error("sustain tick changed the envelope");

  a_note_off_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == ACT_NOTE_OFF |=> phase_q == PH_RELEASE)
    else $error("note-off did not enter release");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(lvl_q) && $stable(phase_q))
    else $error("envelope state moved without a step");

endmodule

[design/adsr_envelope_generator.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_generator: linear ADSR envelope generator, top level
// Path: a tick accepted into item register s1 is loaded into the result
// register when s1 advances, once a result slot is free; with no such stall
// throughput is one item per cycle; the level feedback is one add and compare.
// Note-on and note-off beats update the state and produce no result beat.
// Reset: registers take their default values, phase ended, level zero, ready
// right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module adsr_envelope_generator import adsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  adsr_cfg_if.sink    cfg_i,
  adsr_item_if.sink   item_i,
  adsr_result_if.source result_o
);

  cfg_t             cfg;
  item_t            s1_q;
  logic             s1_valid_q;
  logic             s1_tick, s1_adv, out_free, in_acc;
  logic             res_valid_q;
  logic [OUT_W-1:0] res_level_q;
  logic [PH_W-1:0]  res_phase_q;
  logic [OUT_W-1:0] core_level;
  phase_e           core_phase;

  adsr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // A tick needs a free result slot; note beats advance unconditionally
  assign s1_tick  = s1_q.action == ACT_TICK;
  assign out_free = !res_valid_q || result_o.ready;
  assign s1_adv   = s1_valid_q && (!s1_tick || out_free);

  assign item_i.ready = !s1_valid_q || s1_adv;
  assign in_acc       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.action              <= item_i.action;
      s1_q.zero_level_on_start <= item_i.zero_level_on_start;
      s1_q.hold_sustain        <= item_i.hold_sustain;
    end
  end

  adsr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .item_i  (s1_q),
    .cfg_i   (cfg),
    .level_o (core_level),
    .phase_o (core_phase)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv && s1_tick) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_tick) begin
      res_level_q <= core_level;
      res_phase_q <= core_phase;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.level = res_level_q;
  assign result_o.phase = res_phase_q;

endmodule
